/* rtl/ethernet_ipv4_l4_header_parser_macros.svh */
// assertion helpers for the header parser, sampled on clk with rst_n low as disable
`ifndef ETHERNET_IPV4_L4_HEADER_PARSER_MACROS_SVH
`define ETHERNET_IPV4_L4_HEADER_PARSER_MACROS_SVH

// same-cycle implication
`define HP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hp_pkg.sv */
package hp_pkg;

  // byte offsets in the frame
  localparam int POS_TYPE_HI = 12;
  localparam int POS_TYPE_LO = 13;
  localparam int POS_VIHL    = 14;
  localparam int POS_PROTO   = 23;
  localparam int POS_SRC_FST = 26;
  localparam int POS_SRC_LST = 29;
  localparam int POS_DST_FST = 30;
  localparam int POS_DST_LST = 33;

  // header lengths in bytes
  localparam int ETH_HDR_LEN = 14;
  localparam int IP_HDR_END  = 34;
  localparam int TCP_HDR_LEN = 20;
  localparam int UDP_HDR_LEN = 8;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  IPV4_VERSION   = 4'd4;
  localparam logic [3:0]  IHL_MIN        = 4'd5;

  // captured header fields of one frame
  typedef struct packed {
    logic [15:0] eth_type;
    logic [7:0]  ver_ihl;
    logic [7:0]  proto;
    logic [31:0] ip_saddr;
    logic [31:0] ip_daddr;
    logic [15:0] l4_sport;
    logic [15:0] l4_dport;
  } hp_hdr_t;

  // L4 header offset from the IHL nibble (at most 74)
  function automatic logic [6:0] l4_start(input logic [3:0] ihl);
    l4_start = 7'(ETH_HDR_LEN) + {1'b0, ihl, 2'b00};
  endfunction

endpackage

/* rtl/hp_ifs.sv */
// byte stream channel
interface hp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// parse summary channel
interface hp_sum_if;
  logic        valid;
  logic        ready;
  logic        parse_ok;
  logic [15:0] eth_type;
  logic        ipv4_ok;
  logic [7:0]  l3_proto;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic        has_l4;
  logic [15:0] l4_sport;
  logic [15:0] l4_dport;

  modport source (
    output valid, output parse_ok, output eth_type, output ipv4_ok, output l3_proto,
    output src_ip, output dst_ip, output has_l4, output l4_sport, output l4_dport,
    input ready
  );
  modport sink (
    input valid, input parse_ok, input eth_type, input ipv4_ok, input l3_proto,
    input src_ip, input dst_ip, input has_l4, input l4_sport, input l4_dport,
    output ready
  );
endinterface

/* rtl/hp_capture.sv */
module hp_capture #(
  parameter int CNT_W   = 7,
  parameter int CNT_MAX = 127
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hp_byte_if.sink              in_ch,
  output logic                 snap_valid_o,
  input  logic                 snap_ready_i,
  output logic [CNT_W-1:0]     snap_cnt_o,
  output hp_pkg::hp_hdr_t      snap_hdr_o
);
  import hp_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  hp_hdr_t          hdr_r, hdr_nxt;
  logic             snap_valid_r;
  logic [CNT_W-1:0] snap_cnt_r;
  hp_hdr_t          snap_hdr_r;
  logic [3:0]       ihl;
  logic [6:0]       l4_off;
  logic             in_acc;

  assign in_ch.ready = !snap_valid_r || snap_ready_i;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // field capture at the current byte position
  always_comb begin
    hdr_nxt = hdr_r;
    cnt_nxt = cnt_r;
    ihl     = hdr_r.ver_ihl[3:0];
    l4_off  = l4_start(ihl);
    if (cnt_r < CNT_W'(CNT_MAX)) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(POS_TYPE_HI) || cnt_r == CNT_W'(POS_TYPE_LO)) begin
        hdr_nxt.eth_type = {hdr_r.eth_type[7:0], in_ch.data_byte};
      end else if (cnt_r == CNT_W'(POS_VIHL)) begin
        hdr_nxt.ver_ihl = in_ch.data_byte;
      end else if (cnt_r == CNT_W'(POS_PROTO)) begin
        hdr_nxt.proto = in_ch.data_byte;
      end else if (cnt_r >= CNT_W'(POS_SRC_FST) && cnt_r <= CNT_W'(POS_SRC_LST)) begin
        hdr_nxt.ip_saddr = {hdr_r.ip_saddr[23:0], in_ch.data_byte};
      end else if (cnt_r >= CNT_W'(POS_DST_FST) && cnt_r <= CNT_W'(POS_DST_LST)) begin
        hdr_nxt.ip_daddr = {hdr_r.ip_daddr[23:0], in_ch.data_byte};
      end
      // ports sit right after the variable-length IPv4 header
      if (cnt_r >= CNT_W'(IP_HDR_END) && ihl >= IHL_MIN) begin
        if (cnt_r == CNT_W'(l4_off) || cnt_r == CNT_W'(l4_off + 7'd1)) begin
          hdr_nxt.l4_sport = {hdr_r.l4_sport[7:0], in_ch.data_byte};
        end else if (cnt_r == CNT_W'(l4_off + 7'd2) || cnt_r == CNT_W'(l4_off + 7'd3)) begin
          hdr_nxt.l4_dport = {hdr_r.l4_dport[7:0], in_ch.data_byte};
        end
      end
    end
  end

  // frame state, cleared after each last word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      hdr_r        <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      if (in_acc && in_ch.last_byte) begin
        snap_valid_r <= 1'b1;
      end else if (snap_ready_i) begin
        snap_valid_r <= 1'b0;
      end
      if (in_acc) begin
        if (in_ch.last_byte) begin
          cnt_r <= '0;
          hdr_r <= '0;
        end else begin
          cnt_r <= cnt_nxt;
          hdr_r <= hdr_nxt;
        end
      end
    end
  end

  // snapshot of the finished frame
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last_byte) begin
      snap_cnt_r <= cnt_nxt;
      snap_hdr_r <= hdr_nxt;
    end
  end

  assign snap_valid_o = snap_valid_r;
  assign snap_cnt_o   = snap_cnt_r;
  assign snap_hdr_o   = snap_hdr_r;

endmodule

/* rtl/hp_summary.sv */
module hp_summary #(
  parameter int CNT_W = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 snap_valid_i,
  output logic                 snap_ready_o,
  input  logic [CNT_W-1:0]     snap_cnt_i,
  input  hp_pkg::hp_hdr_t      snap_hdr_i,
  hp_sum_if.source             out_ch
);
  import hp_pkg::*;

  logic        out_valid_r;
  logic        parse_ok_r, parse_ok_nxt;
  logic [15:0] eth_type_r, eth_type_nxt;
  logic        ipv4_ok_r, ipv4_ok_nxt;
  logic [7:0]  l3_proto_r, l3_proto_nxt;
  logic [31:0] src_ip_r, src_ip_nxt;
  logic [31:0] dst_ip_r, dst_ip_nxt;
  logic        has_l4_r, has_l4_nxt;
  logic [15:0] l4_sport_r, l4_sport_nxt;
  logic [15:0] l4_dport_r, l4_dport_nxt;
  logic [6:0]  l4_off;
  logic        tcp_fit, udp_fit;

  assign snap_ready_o = !out_valid_r || out_ch.ready;

  // validity checks and zeroing of fields not found
  always_comb begin
    l4_off  = l4_start(snap_hdr_i.ver_ihl[3:0]);
    tcp_fit = snap_hdr_i.proto == PROTO_TCP &&
              snap_cnt_i >= CNT_W'(l4_off + 7'(TCP_HDR_LEN));
    udp_fit = snap_hdr_i.proto == PROTO_UDP &&
              snap_cnt_i >= CNT_W'(l4_off + 7'(UDP_HDR_LEN));

    parse_ok_nxt = snap_cnt_i >= CNT_W'(ETH_HDR_LEN);
    ipv4_ok_nxt  = parse_ok_nxt && snap_hdr_i.eth_type == ETHERTYPE_IPV4 &&
                   snap_cnt_i >= CNT_W'(IP_HDR_END) &&
                   snap_hdr_i.ver_ihl[7:4] == IPV4_VERSION;
    has_l4_nxt   = ipv4_ok_nxt && snap_hdr_i.ver_ihl[3:0] >= IHL_MIN &&
                   (tcp_fit || udp_fit);

    eth_type_nxt = parse_ok_nxt ? snap_hdr_i.eth_type : '0;
    l3_proto_nxt = ipv4_ok_nxt ? snap_hdr_i.proto : '0;
    src_ip_nxt   = ipv4_ok_nxt ? snap_hdr_i.ip_saddr : '0;
    dst_ip_nxt   = ipv4_ok_nxt ? snap_hdr_i.ip_daddr : '0;
    l4_sport_nxt = has_l4_nxt ? snap_hdr_i.l4_sport : '0;
    l4_dport_nxt = has_l4_nxt ? snap_hdr_i.l4_dport : '0;
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (snap_ready_o) begin
      out_valid_r <= snap_valid_i;
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (snap_valid_i && snap_ready_o) begin
      parse_ok_r <= parse_ok_nxt;
      eth_type_r <= eth_type_nxt;
      ipv4_ok_r  <= ipv4_ok_nxt;
      l3_proto_r <= l3_proto_nxt;
      src_ip_r   <= src_ip_nxt;
      dst_ip_r   <= dst_ip_nxt;
      has_l4_r   <= has_l4_nxt;
      l4_sport_r <= l4_sport_nxt;
      l4_dport_r <= l4_dport_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.parse_ok = parse_ok_r;
  assign out_ch.eth_type = eth_type_r;
  assign out_ch.ipv4_ok  = ipv4_ok_r;
  assign out_ch.l3_proto = l3_proto_r;
  assign out_ch.src_ip   = src_ip_r;
  assign out_ch.dst_ip   = dst_ip_r;
  assign out_ch.has_l4   = has_l4_r;
  assign out_ch.l4_sport = l4_sport_r;
  assign out_ch.l4_dport = l4_dport_r;

endmodule

/* rtl/ethernet_ipv4_l4_header_parser.sv */
// Ethernet / IPv4 / TCP-UDP header parser.
// in_ch carries one frame byte per word, starting at the destination MAC, with
// last_byte set on the final word. out_ch carries one summary word per frame:
// EtherType, IPv4 protocol and addresses, L4 ports, and their found flags.
// Fields not present in the frame read as zero.
// Throughput: one byte per cycle while in_ch.ready is high.
// The summary passes through the snapshot register, then the output register,
// after the last byte is taken.
// The byte count saturates at BYTE_COUNT_MAX; later bytes are ignored.
// Reset (rst_n low, synchronous) clears the byte count, the fields of the frame
// being captured and both pipeline valids; no summary is pending afterwards.
// When out_ch.ready is low the summary holds; the block keeps taking bytes
// until a second finished frame waits in the snapshot register, then drops
// in_ch.ready until the output word is taken.
`include "ethernet_ipv4_l4_header_parser_macros.svh"

module ethernet_ipv4_l4_header_parser #(
  parameter int BYTE_COUNT_MAX = 127
) (
  input  logic      clk,
  input  logic      rst_n,
  hp_byte_if.sink   in_ch,
  hp_sum_if.source  out_ch
);
  import hp_pkg::*;

  localparam int CNT_W = $clog2(BYTE_COUNT_MAX + 1);

  logic             snap_valid;
  logic             snap_ready;
  logic [CNT_W-1:0] snap_cnt;
  hp_hdr_t          snap_hdr;

  // byte counter and field capture
  hp_capture #(
    .CNT_W   (CNT_W),
    .CNT_MAX (BYTE_COUNT_MAX)
  ) u_capture (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_cnt_o   (snap_cnt),
    .snap_hdr_o   (snap_hdr)
  );

  // validity checks and output register
  hp_summary #(
    .CNT_W (CNT_W)
  ) u_summary (
    .clk          (clk),
    .rst_n        (rst_n),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_cnt_i   (snap_cnt),
    .snap_hdr_i   (snap_hdr),
    .out_ch       (out_ch)
  );

  // checks
  `HP_ASSERT_NXT(a_last_to_snap, in_ch.valid && in_ch.ready && in_ch.last_byte, snap_valid, "last byte did not produce a snapshot")
  `HP_ASSERT_NXT(a_snap_to_out, snap_valid && snap_ready, out_ch.valid, "snapshot not moved to output")
  `HP_ASSERT_IMP(a_l4_needs_ip, out_ch.valid && out_ch.has_l4, out_ch.ipv4_ok && out_ch.parse_ok, "has_l4 without IPv4 header")
  `HP_ASSERT_IMP(a_ip_zero, out_ch.valid && !out_ch.ipv4_ok, out_ch.src_ip == 32'd0 && out_ch.dst_ip == 32'd0 && out_ch.l3_proto == 8'd0, "IPv4 fields not zeroed")

endmodule
